FILE: hw/rtl/aesc_pkg.sv
// shared types, constants and functions for the aes block cipher core
package aesc_pkg;

   localparam int NumWords = 60;
   localparam int WordIdxW = 6;
   localparam int CsrAddrW = 6;

   // register byte addresses
   localparam logic [CsrAddrW-1:0] CsrKeySize = 6'd0;
   localparam logic [CsrAddrW-1:0] CsrKey0    = 6'd8;
   localparam logic [CsrAddrW-1:0] CsrKey1    = 6'd16;
   localparam logic [CsrAddrW-1:0] CsrKey2    = 6'd24;
   localparam logic [CsrAddrW-1:0] CsrKey3    = 6'd32;

   localparam logic OpEncrypt = 1'b0;
   localparam logic OpDecrypt = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EXP   = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_KEY0  = 7'b0001000,
      ST_ROUND = 7'b0010000,
      ST_LAST  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] ISBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

FILE: hw/rtl/aesc_round.sv
// shared aes round unit: one forward or inverse round on a 128-bit state
module aesc_round (
   input  logic         decrypt,
   input  logic         do_mix,
   input  logic [127:0] state_in,
   input  logic [127:0] round_key,
   output logic [127:0] state_out
);

   // byte k of the block sits at [127-8k -: 8]; k = 4*col + row
   logic [7:0] sin  [16];
   logic [7:0] sh   [16];
   logic [7:0] sb   [16];
   logic [7:0] mx   [16];
   logic [7:0] rk   [16];
   logic [7:0] fin  [16];
   logic [7:0] x2, x4, x8;
   logic [7:0] a0, a1, a2, a3;
   logic [7:0] t [4][4];

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         sin[k] = state_in[127-8*k -: 8];
         rk[k]  = round_key[127-8*k -: 8];
      end
      // forward and inverse: shift then sub (sub and shift commute)
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (decrypt) begin
               sh[4*c+r] = sin[4*((c+4-r)%4)+r];
               sb[4*c+r] = aesc_pkg::ISBOX[sh[4*c+r]];
            end else begin
               sh[4*c+r] = sin[4*((c+r)%4)+r];
               sb[4*c+r] = aesc_pkg::SBOX[sh[4*c+r]];
            end
         end
      end
      // key added ahead of the inverse mix
      for (int k = 0; k < 16; k++) begin
         t[k/4][k%4] = sb[k] ^ rk[k];
      end
      x2 = '0; x4 = '0; x8 = '0;
      a0 = '0; a1 = '0; a2 = '0; a3 = '0;
      if (!decrypt) begin
         // encrypt: mix then add key
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               a0 = sb[4*c+r];
               a1 = sb[4*c+(r+1)%4];
               a2 = sb[4*c+(r+2)%4];
               a3 = sb[4*c+(r+3)%4];
               mx[4*c+r] = aesc_pkg::xtime(a0) ^ aesc_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
            end
         end
         for (int k = 0; k < 16; k++)
            fin[k] = (do_mix ? mx[k] : sb[k]) ^ rk[k];
      end else begin
         // decrypt: add key then inverse mix
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               a0 = t[c][r];
               a1 = t[c][(r+1)%4];
               a2 = t[c][(r+2)%4];
               a3 = t[c][(r+3)%4];
               // 0e*a0 ^ 0b*a1 ^ 0d*a2 ^ 09*a3
               x2 = aesc_pkg::xtime(a0 ^ a1);
               x4 = aesc_pkg::xtime(aesc_pkg::xtime(a0 ^ a2));
               x8 = aesc_pkg::xtime(aesc_pkg::xtime(aesc_pkg::xtime(a0 ^ a1 ^ a2 ^ a3)));
               mx[4*c+r] = x8 ^ x4 ^ x2 ^ a1 ^ a2 ^ a3;
            end
         end
         for (int k = 0; k < 16; k++)
            fin[k] = do_mix ? mx[k] : t[k/4][k%4];
      end
      for (int k = 0; k < 16; k++) state_out[127-8*k -: 8] = fin[k];
   end

endmodule

FILE: hw/rtl/aes_block_cipher_enc_dec_core.sv
// top level of the aes-128/192/256 ecb block cipher core
//
// channel | dir | tdata fields (low bit up)                | side band
// req     | in  | op, text_high, text_low, 7 zero pad bits | tlast = end_of_message
// rsp     | out | out_high, out_low                        | tlast = end_of_message_out
// csr     | apb | key_size @0, key_bits_0..3 @8,16,24,32   | 64-bit data, paddr[2:0] ignored
//
// with a cached schedule each block runs the first key add in ST_KEY0, then nr
// rounds in ST_ROUND on the shared round unit (nr is 10, 12 or 14), then returns to
// ST_IDLE, where the next block is taken
// after reset or any register write the next block first rebuilds the schedule
// of 4*nr+4 words, one word per cycle, then fetches key 0 in ST_LOAD
// reset is synchronous active high; req_tready is low while a block is in work,
// and the last round holds while the previous result still waits for rsp_tready
module aes_block_cipher_enc_dec_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // op, text_high, text_low, 7 zero bits
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // out_high, out_low
   output logic         rsp_tlast,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [aesc_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [63:0]                   csr_pwdata,
   output logic [63:0]                   csr_prdata,
   output logic                          csr_pready
);

   // configuration registers
   logic [1:0]  key_size_ff;
   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff;
   logic        sched_ok_ff;
   logic        csr_wr;
   logic [aesc_pkg::CsrAddrW-1:0] csr_reg;   // register address, byte lanes dropped

   // key geometry
   logic [3:0] nk;
   logic [3:0] nr;
   logic [5:0] total;

   // round key memory: one row of four words per round
   logic [3:0][31:0] rk_mem [15];
   logic [127:0]     rk_rd_ff;       // round key for the next round step
   logic [31:0]      win_ff [8];     // win_ff[0] is w[i-1], win_ff[j] w[i-1-j]
   logic [5:0]       widx_ff;        // word being generated
   logic [3:0]       pos_ff;         // i mod nk
   logic [7:0]       rcon_ff;

   // sequencer and datapath
   aesc_pkg::state_type st_ff, st_in;
   logic [3:0]   rnd_ff;             // round now applied, 1..nr
   logic [127:0] blk_ff;
   logic         dec_ff;
   logic         last_ff;
   logic [127:0] rsp_data_ff;
   logic         rsp_last_ff;
   logic         rsp_valid_ff;

   // schedule word generator
   logic [31:0] wprev, wnk, tword, wnew, init_word;
   logic        init_phase;
   logic [31:0] gen_word;

   // key fetch
   logic       rd_en;
   logic       rd_dec;
   logic [3:0] rd_rnd;               // round whose key is fetched
   logic [3:0] rd_row;

   logic         req_hs;
   logic         out_free;
   logic         final_rnd;
   logic         round_step;
   logic [127:0] round_out;

   assign csr_pready = 1'b1;
   assign csr_wr  = csr_psel & csr_penable & csr_pwrite;
   assign csr_reg = {csr_paddr[5:3], 3'b000};

   always_comb begin
      case (csr_reg)
         aesc_pkg::CsrKeySize: csr_prdata = {62'd0, key_size_ff};
         aesc_pkg::CsrKey0:    csr_prdata = key0_ff;
         aesc_pkg::CsrKey1:    csr_prdata = key1_ff;
         aesc_pkg::CsrKey2:    csr_prdata = key2_ff;
         aesc_pkg::CsrKey3:    csr_prdata = key3_ff;
         default:              csr_prdata = '0;
      endcase
   end

   // size 3 acts as 256
   always_comb begin
      case (key_size_ff)
         2'd0:    begin nk = 4'd4; nr = 4'd10; end
         2'd1:    begin nk = 4'd6; nr = 4'd12; end
         default: begin nk = 4'd8; nr = 4'd14; end
      endcase
      total = 6'({nr, 2'b00}) + 6'd3; // last word index
   end

   always_comb begin
      wprev = win_ff[0];
      wnk   = win_ff[3'(nk - 4'd1)];
      tword = wprev;
      if (pos_ff == 4'd0)
         tword = aesc_pkg::sub_word({wprev[23:0], wprev[31:24]}) ^ {rcon_ff, 24'd0};
      else if (nk == 4'd8 && pos_ff == 4'd4)
         tword = aesc_pkg::sub_word(wprev);
      wnew = wnk ^ tword;
      case (widx_ff[2:1])
         2'd0:    init_word = widx_ff[0] ? key0_ff[31:0] : key0_ff[63:32];
         2'd1:    init_word = widx_ff[0] ? key1_ff[31:0] : key1_ff[63:32];
         2'd2:    init_word = widx_ff[0] ? key2_ff[31:0] : key2_ff[63:32];
         default: init_word = widx_ff[0] ? key3_ff[31:0] : key3_ff[63:32];
      endcase
   end
   assign init_phase = ({2'b00, widx_ff} < {4'd0, nk});
   assign gen_word = init_phase ? init_word : wnew;

   assign req_hs     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign final_rnd  = (rnd_ff == nr);
   // the last round only runs once the result register is free
   assign round_step = (st_ff == aesc_pkg::ST_ROUND) && (!final_rnd || out_free);

   // the key for the coming step is registered in rk_rd_ff ahead of it; decrypt walks rows down
   always_comb begin
      rd_en  = 1'b0;
      rd_dec = dec_ff;
      rd_rnd = 4'd0;
      case (st_ff)
         aesc_pkg::ST_IDLE: begin
            rd_en  = 1'b1;
            rd_dec = req_tdata[0];
         end
         aesc_pkg::ST_LOAD: rd_en = 1'b1;
         aesc_pkg::ST_KEY0: begin
            rd_en  = 1'b1;
            rd_rnd = rnd_ff;
         end
         aesc_pkg::ST_ROUND: begin
            rd_en  = round_step && !final_rnd;
            rd_rnd = rnd_ff + 4'd1;
         end
         default: ;
      endcase
      rd_row = rd_dec ? (nr - rd_rnd) : rd_rnd;
   end

   always_ff @(posedge clock) begin
      if (st_ff == aesc_pkg::ST_EXP) rk_mem[widx_ff[5:2]][2'd3 - widx_ff[1:0]] <= gen_word;
      if (rd_en) rk_rd_ff <= rk_mem[rd_row];
   end

   aesc_round u_round (
      .decrypt   (dec_ff),
      .do_mix    (!final_rnd),
      .state_in  (blk_ff),
      .round_key (rk_rd_ff),
      .state_out (round_out)
   );

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         aesc_pkg::ST_IDLE:
            if (req_hs) st_in = sched_ok_ff ? aesc_pkg::ST_KEY0 : aesc_pkg::ST_EXP;
         aesc_pkg::ST_EXP:
            if (widx_ff == total) st_in = aesc_pkg::ST_LOAD;
         aesc_pkg::ST_LOAD:
            st_in = aesc_pkg::ST_KEY0;
         aesc_pkg::ST_KEY0:
            st_in = aesc_pkg::ST_ROUND;
         aesc_pkg::ST_ROUND:
            if (round_step && final_rnd) st_in = aesc_pkg::ST_IDLE;
         default:
            st_in = aesc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= aesc_pkg::ST_IDLE;
         key_size_ff  <= '0;
         key0_ff      <= '0;
         key1_ff      <= '0;
         key2_ff      <= '0;
         key3_ff      <= '0;
         sched_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_wr) begin
            case (csr_reg)
               aesc_pkg::CsrKeySize: begin
                  key_size_ff <= csr_pwdata[1:0];
                  sched_ok_ff <= 1'b0;
               end
               aesc_pkg::CsrKey0: begin key0_ff <= csr_pwdata; sched_ok_ff <= 1'b0; end
               aesc_pkg::CsrKey1: begin key1_ff <= csr_pwdata; sched_ok_ff <= 1'b0; end
               aesc_pkg::CsrKey2: begin key2_ff <= csr_pwdata; sched_ok_ff <= 1'b0; end
               aesc_pkg::CsrKey3: begin key3_ff <= csr_pwdata; sched_ok_ff <= 1'b0; end
               default: ;
            endcase
         end else if (st_ff == aesc_pkg::ST_EXP && widx_ff == total) begin
            sched_ok_ff <= 1'b1;
         end
         if (round_step && final_rnd) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)         rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (st_ff)
         aesc_pkg::ST_IDLE: begin
            blk_ff  <= {req_tdata[64:1], req_tdata[128:65]};
            dec_ff  <= req_tdata[0];
            last_ff <= req_tlast;
            widx_ff <= '0;
            pos_ff  <= '0;
            rcon_ff <= 8'h01;
            rnd_ff  <= 4'd1;
         end
         aesc_pkg::ST_EXP: begin
            widx_ff <= widx_ff + 6'd1;
            win_ff[0] <= gen_word;
            for (int j = 1; j < 8; j++) win_ff[j] <= win_ff[j-1];
            if (pos_ff == nk - 4'd1) begin
               pos_ff <= '0;
            end else begin
               pos_ff <= pos_ff + 4'd1;
            end
            if (!init_phase && pos_ff == 4'd0) rcon_ff <= aesc_pkg::xtime(rcon_ff);
         end
         aesc_pkg::ST_KEY0: begin
            blk_ff <= blk_ff ^ rk_rd_ff;
         end
         aesc_pkg::ST_ROUND: begin
            if (round_step) begin
               blk_ff <= round_out;
               if (final_rnd) begin
                  rsp_data_ff <= round_out;
                  rsp_last_ff <= last_ff;
               end else begin
                  rnd_ff <= rnd_ff + 4'd1;
               end
            end
         end
         default: ;
      endcase
   end

   assign req_tready = (st_ff == aesc_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff[63:0], rsp_data_ff[127:64]};
   assign rsp_tlast  = rsp_last_ff;

   // a waiting result holds still until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast));

   // the sequencer stays one-hot
   assert property (@(posedge clock) disable iff (reset) $onehot(st_ff));

   // no transaction is taken while a block is in work
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> st_ff == aesc_pkg::ST_IDLE);

   // round counter stays inside the active key size
   assert property (@(posedge clock) disable iff (reset)
      st_ff == aesc_pkg::ST_ROUND |-> rnd_ff != 4'd0 && rnd_ff <= nr);

endmodule
